// ----- src/sep_pkg.sv -----
// Shared constants for the superellipse point generator.
// Fixed-point formats, polynomial coefficients and pipeline depths.
// No dependencies.
package sep_pkg;

    // Default widths of the sample and phase fields
    localparam int SEP_SAMPLE_WIDTH = 16;
    localparam int SEP_PHASE_WIDTH  = 16;

    // Exponent field, unsigned Q8.8
    localparam int EXPO_W = 16;

    // Q30 unity and ln2
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Quarter-sine Taylor coefficients, highest order first
    localparam logic [30:0] SIN_COEF [5] = '{
        31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };

    // Log fraction bits, quotient bits and exp series terms
    localparam int FRAC_BITS = 24;
    localparam int LOG_STEPS = FRAC_BITS;
    localparam int QUOT_BITS = 29;
    localparam int EXP_TERMS = 12;

    // Pipeline depths
    localparam int SINE_LAT = 7;
    localparam int AXIS_LAT = 1 + LOG_STEPS + 1 + QUOT_BITS + 1 + 2 * EXP_TERMS + 3;
    localparam int PIPE_LAT = SINE_LAT + AXIS_LAT;

endpackage

// ----- src/sep_log_cell.sv -----
// One squaring step of the base-2 logarithm fraction.
// Depends on sep_pkg.
module sep_log_cell
    import sep_pkg::*;
#(
    parameter int SIDE_W = 8
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [30:0]          z_in,
    input  logic [FRAC_BITS-1:0] frac_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic [30:0]          z_out,
    output logic [FRAC_BITS-1:0] frac_out,
    output logic [SIDE_W-1:0]    side_out
);

    logic [61:0] sq;
    logic [31:0] zs;
    logic [30:0] z_next;
    logic [FRAC_BITS-1:0] frac_next;
    logic [30:0] z_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [SIDE_W-1:0] side_reg;

    // Square and renormalize, shifting one fraction bit in
    always_comb
    begin
        sq = 62'(z_in) * 62'(z_in);
        zs = sq[61:30];
        if (zs[31])
        begin
            z_next    = zs[31:1];
            frac_next = {frac_in[FRAC_BITS-2:0], 1'b1};
        end
        else
        begin
            z_next    = zs[30:0];
            frac_next = {frac_in[FRAC_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg    <= z_next;
            frac_reg <= frac_next;
            side_reg <= side_in;
        end
    end

    assign z_out    = z_reg;
    assign frac_out = frac_reg;
    assign side_out = side_reg;

endmodule

// ----- src/sep_div_cell.sv -----
// One restoring step of the exponent division.
// Depends on sep_pkg.
module sep_div_cell
    import sep_pkg::*;
#(
    parameter int SIDE_W = 8
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [EXPO_W-1:0]    rem_in,
    input  logic [QUOT_BITS-1:0] dq_in,
    input  logic [EXPO_W-1:0]    n_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic [EXPO_W-1:0]    rem_out,
    output logic [QUOT_BITS-1:0] dq_out,
    output logic [EXPO_W-1:0]    n_out,
    output logic [SIDE_W-1:0]    side_out
);

    logic [EXPO_W:0]      r_sh;
    logic [EXPO_W-1:0]    rem_next;
    logic [QUOT_BITS-1:0] dq_next;
    logic [EXPO_W-1:0]    rem_reg;
    logic [QUOT_BITS-1:0] dq_reg;
    logic [EXPO_W-1:0]    n_reg;
    logic [SIDE_W-1:0]    side_reg;

    // Bring in the next dividend bit, subtract when it fits
    always_comb
    begin
        r_sh = {rem_in, dq_in[QUOT_BITS-1]};
        if (r_sh >= {1'b0, n_in})
        begin
            rem_next = EXPO_W'(r_sh - {1'b0, n_in});
            dq_next  = {dq_in[QUOT_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next = r_sh[EXPO_W-1:0];
            dq_next  = {dq_in[QUOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
            n_reg    <= n_in;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign dq_out   = dq_reg;
    assign n_out    = n_reg;
    assign side_out = side_reg;

endmodule

// ----- src/sep_exp_cell.sv -----
// One Horner term of the e^-y series, over two register stages.
// Depends on sep_pkg.
module sep_exp_cell
    import sep_pkg::*;
#(
    parameter int SIDE_W  = 8,
    parameter int DIVISOR = 1
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [30:0]       t_in,
    input  logic [29:0]       y_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic [30:0]       t_out,
    output logic [29:0]       y_out,
    output logic [SIDE_W-1:0] side_out
);

    // Reciprocal of the term index, exact for 30-bit dividends
    localparam logic [34:0] RECIP = 35'(((64'd1 << 34) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [60:0] yt;
    logic [64:0] qp;
    logic [30:0] t_next;
    logic [29:0] v_reg;
    logic [29:0] ya_reg;
    logic [SIDE_W-1:0] sa_reg;
    logic [30:0] t_reg;
    logic [29:0] y_reg;
    logic [SIDE_W-1:0] side_reg;

    // Multiply by y, then divide by the term index
    always_comb
    begin
        yt     = 61'(y_in) * 61'(t_in);
        qp     = 65'(v_reg) * 65'(RECIP);
        t_next = ONE_Q30 - {1'b0, qp[63:34]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg    <= yt[59:30];
            ya_reg   <= y_in;
            sa_reg   <= side_in;
            t_reg    <= t_next;
            y_reg    <= ya_reg;
            side_reg <= sa_reg;
        end
    end

    assign t_out    = t_reg;
    assign y_out    = y_reg;
    assign side_out = side_reg;

endmodule

// ----- src/sep_axis.sv -----
// Power, scaling and saturation for one coordinate.
// Depends on sep_pkg, sep_log_cell, sep_div_cell and sep_exp_cell.
module sep_axis
    import sep_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SEP_SAMPLE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           en,
    input  logic [30:0]                    trig,
    input  logic                           trig_neg,
    input  logic signed [SAMPLE_WIDTH-1:0] amp,
    input  logic [EXPO_W-1:0]              n,
    output logic signed [SAMPLE_WIDTH-1:0] point
);

    typedef enum logic [1:0] {MODE_NORM, MODE_ZERO, MODE_ONE} mode_t;

    typedef struct packed {
        mode_t                   mode;
        logic                    sgn;
        logic [SAMPLE_WIDTH-1:0] amag;
        logic [EXPO_W-1:0]       n;
        logic [4:0]              e;
    } log_side_t;

    typedef struct packed {
        mode_t                   mode;
        logic                    sgn;
        logic [SAMPLE_WIDTH-1:0] amag;
    } div_side_t;

    typedef struct packed {
        mode_t                   mode;
        logic                    sgn;
        logic [SAMPLE_WIDTH-1:0] amag;
        logic [4:0]              ip;
    } exp_side_t;

    localparam int LS_W = $bits(log_side_t);
    localparam int DS_W = $bits(div_side_t);
    localparam int ES_W = $bits(exp_side_t);
    localparam logic [SAMPLE_WIDTH:0] HALF = (SAMPLE_WIDTH+1)'(1) << (SAMPLE_WIDTH - 1);

    // Normalize the magnitude and split the amplitude sign
    logic [29:0] nv;
    logic [4:0]  nsh;
    log_side_t   ls_next;
    logic [30:0] z0_reg;
    log_side_t   ls0_reg;

    always_comb
    begin
        nv  = trig[29:0];
        nsh = '0;
        for (int i = 4; i >= 0; i--)
        begin
            if ((nv >> (30 - (1 << i))) == '0)
            begin
                nv  = nv << (1 << i);
                nsh = nsh + 5'(1 << i);
            end
        end
        if (trig == '0)
            ls_next.mode = MODE_ZERO;
        else if (trig[30])
            ls_next.mode = MODE_ONE;
        else
            ls_next.mode = MODE_NORM;
        ls_next.sgn  = trig_neg ^ amp[SAMPLE_WIDTH-1];
        ls_next.amag = amp[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-amp) : SAMPLE_WIDTH'(amp);
        ls_next.n    = n;
        ls_next.e    = nsh + 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg  <= {nv, 1'b0};
            ls0_reg <= ls_next;
        end
    end

    // Chain of squaring cells for the log fraction
    logic [30:0]          lz [LOG_STEPS+1];
    logic [FRAC_BITS-1:0] lf [LOG_STEPS+1];
    logic [LS_W-1:0]      lsd [LOG_STEPS+1];

    assign lz[0]  = z0_reg;
    assign lf[0]  = '0;
    assign lsd[0] = ls0_reg;

    for (genvar g = 0; g < LOG_STEPS; g++)
    begin : g_log
        sep_log_cell #(.SIDE_W(LS_W)) u_cell (
            .clk      (clk),
            .en       (en),
            .z_in     (lz[g]),
            .frac_in  (lf[g]),
            .side_in  (lsd[g]),
            .z_out    (lz[g+1]),
            .frac_out (lf[g+1]),
            .side_out (lsd[g+1])
        );
    end

    // Form -log2 scaled by 512 and seed the divider
    log_side_t lsl;
    logic [28:0] neg;
    logic [EXPO_W-1:0] r0;
    div_side_t ds_next;
    logic [EXPO_W-1:0]    rem0_reg;
    logic [QUOT_BITS-1:0] dq0_reg;
    logic [EXPO_W-1:0]    n0_reg;
    div_side_t            ds0_reg;

    always_comb
    begin
        lsl  = log_side_t'(lsd[LOG_STEPS]);
        neg  = {lsl.e, 24'd0} - {5'd0, lf[LOG_STEPS]};
        r0   = EXPO_W'(neg[28:20]);
        ds_next.sgn  = lsl.sgn;
        ds_next.amag = lsl.amag;
        if (lsl.mode == MODE_NORM && r0 >= lsl.n)
            ds_next.mode = MODE_ZERO;
        else
            ds_next.mode = lsl.mode;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem0_reg <= r0;
            dq0_reg  <= {neg[19:0], 9'd0};
            n0_reg   <= lsl.n;
            ds0_reg  <= ds_next;
        end
    end

    // Chain of restoring division cells
    logic [EXPO_W-1:0]    drem [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] ddq  [QUOT_BITS+1];
    logic [EXPO_W-1:0]    dn   [QUOT_BITS+1];
    logic [DS_W-1:0]      dsd  [QUOT_BITS+1];

    assign drem[0] = rem0_reg;
    assign ddq[0]  = dq0_reg;
    assign dn[0]   = n0_reg;
    assign dsd[0]  = ds0_reg;

    for (genvar g = 0; g < QUOT_BITS; g++)
    begin : g_div
        sep_div_cell #(.SIDE_W(DS_W)) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (drem[g]),
            .dq_in    (ddq[g]),
            .n_in     (dn[g]),
            .side_in  (dsd[g]),
            .rem_out  (drem[g+1]),
            .dq_out   (ddq[g+1]),
            .n_out    (dn[g+1]),
            .side_out (dsd[g+1])
        );
    end

    // Split the exponent and scale the fraction by ln2
    div_side_t dsl;
    logic [QUOT_BITS-1:0] pq;
    logic [53:0] yp;
    exp_side_t es_next;
    logic [29:0] y0_reg;
    exp_side_t   es0_reg;

    always_comb
    begin
        dsl = div_side_t'(dsd[QUOT_BITS]);
        pq  = ddq[QUOT_BITS];
        yp  = 54'(pq[FRAC_BITS-1:0]) * 54'(LN2_Q30);
        es_next.sgn  = dsl.sgn;
        es_next.amag = dsl.amag;
        es_next.ip   = pq[QUOT_BITS-1:FRAC_BITS];
        if (dsl.mode == MODE_NORM && pq[QUOT_BITS-1:FRAC_BITS] == 5'd31)
            es_next.mode = MODE_ZERO;
        else
            es_next.mode = dsl.mode;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y0_reg  <= yp[53:24];
            es0_reg <= es_next;
        end
    end

    // Chain of series cells, highest term first
    logic [30:0]     et  [EXP_TERMS+1];
    logic [29:0]     ey  [EXP_TERMS+1];
    logic [ES_W-1:0] esd [EXP_TERMS+1];

    assign et[0]  = ONE_Q30;
    assign ey[0]  = y0_reg;
    assign esd[0] = es0_reg;

    for (genvar g = 0; g < EXP_TERMS; g++)
    begin : g_exp
        sep_exp_cell #(.SIDE_W(ES_W), .DIVISOR(EXP_TERMS - g)) u_cell (
            .clk      (clk),
            .en       (en),
            .t_in     (et[g]),
            .y_in     (ey[g]),
            .side_in  (esd[g]),
            .t_out    (et[g+1]),
            .y_out    (ey[g+1]),
            .side_out (esd[g+1])
        );
    end

    // Apply the integer part of the exponent
    exp_side_t esl;
    logic [30:0] pw_next;
    logic [30:0] pw_reg;
    logic        sgn1_reg;
    logic [SAMPLE_WIDTH-1:0] amag1_reg;

    always_comb
    begin
        esl = exp_side_t'(esd[EXP_TERMS]);
        case (esl.mode)
            MODE_NORM: pw_next = et[EXP_TERMS] >> esl.ip;
            MODE_ONE:  pw_next = ONE_Q30;
            default:   pw_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_reg    <= pw_next;
            sgn1_reg  <= esl.sgn;
            amag1_reg <= esl.amag;
        end
    end

    // Scale by the amplitude magnitude
    logic [SAMPLE_WIDTH+30:0] mp;
    logic [SAMPLE_WIDTH-1:0]  mag_reg;
    logic                     sgn2_reg;

    assign mp = (SAMPLE_WIDTH+31)'(pw_reg) * (SAMPLE_WIDTH+31)'(amag1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mp[SAMPLE_WIDTH+29:30];
            sgn2_reg <= sgn1_reg;
        end
    end

    // Apply the sign and saturate
    logic [SAMPLE_WIDTH:0]   sat;
    logic [SAMPLE_WIDTH-1:0] point_next;
    logic [SAMPLE_WIDTH-1:0] point_reg;

    always_comb
    begin
        if (sgn2_reg)
        begin
            sat        = ({1'b0, mag_reg} > HALF) ? HALF : {1'b0, mag_reg};
            point_next = SAMPLE_WIDTH'(-sat);
        end
        else
        begin
            sat        = ({1'b0, mag_reg} > HALF - 1'b1) ? HALF - 1'b1 : {1'b0, mag_reg};
            point_next = sat[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            point_reg <= point_next;
    end

    assign point = point_reg;

endmodule

// ----- src/superellipse_point_generator.sv -----
// Top level of the superellipse point generator: sine front end and two axes.
// Depends on sep_pkg and sep_axis.
//
//  Group    | Dir | Payload
//  ---------+-----+---------------------------------------------------
//  s_axis   | in  | tdata: phase, amp_x, amp_y, shape_exponent
//  m_axis   | out | tdata: point_x, point_y; tuser: invalid
//
// One beat enters per cycle while the output is not stalled; each result passes
// through the 7-stage sine pipeline and then the 24-cell log chain, the 29-cell
// divider chain and the 12-term two-stage exp chain.
// rst_n clears only the valid and invalid flags of the pipeline.
// A stall on the output freezes the whole pipeline; s_tready drops with it.
module superellipse_point_generator
    import sep_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SEP_SAMPLE_WIDTH,
    parameter int PHASE_WIDTH  = SEP_PHASE_WIDTH,
    localparam int IN_W  = ((PHASE_WIDTH + 2 * SAMPLE_WIDTH + EXPO_W + 7) / 8) * 8,
    localparam int OUT_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // phase, amp_x, amp_y, shape_exponent from bit 0 up
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // point_x, point_y from bit 0 up
    output logic [OUT_W-1:0] m_tdata,
    // invalid
    output logic             m_tuser
);

    localparam int AX_LO = PHASE_WIDTH;
    localparam int AY_LO = PHASE_WIDTH + SAMPLE_WIDTH;
    localparam int N_LO  = PHASE_WIDTH + 2 * SAMPLE_WIDTH;

    typedef struct packed {
        logic [1:0]              quad;
        logic [SAMPLE_WIDTH-1:0] ax;
        logic [SAMPLE_WIDTH-1:0] ay;
        logic [EXPO_W-1:0]       n;
    } sine_side_t;

    typedef struct packed {
        logic vld;
        logic inv;
    } flag_t;

    logic adv;
    flag_t flag_reg [PIPE_LAT];

    assign adv      = !flag_reg[PIPE_LAT-1].vld || m_tready;
    assign s_tready = adv;

    // Advance beat flags along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
                flag_reg[i] <= '0;
        end
        else if (adv)
        begin
            flag_reg[0].vld <= s_tvalid;
            flag_reg[0].inv <= s_tdata[N_LO +: EXPO_W] == '0;
            for (int i = 1; i < PIPE_LAT; i++)
                flag_reg[i] <= flag_reg[i-1];
        end
    end

    // Capture the beat and split the phase into quadrant and fraction
    logic [31:0] p32;
    sine_side_t  side_next;
    logic [29:0] f_reg;
    sine_side_t  side_reg [SINE_LAT];

    always_comb
    begin
        p32 = 32'(s_tdata[PHASE_WIDTH-1:0]) << (32 - PHASE_WIDTH);
        side_next.quad = p32[31:30];
        side_next.ax   = s_tdata[AX_LO +: SAMPLE_WIDTH];
        side_next.ay   = s_tdata[AY_LO +: SAMPLE_WIDTH];
        side_next.n    = s_tdata[N_LO +: EXPO_W];
    end

    // Quarter-sine of f and of 1-f, one Horner step per stage
    logic [30:0] lane_x  [2];
    logic [61:0] sq_prod [2];
    logic [61:0] hp      [2][4];
    logic [61:0] fin     [2];
    logic [30:0] t_next  [2][4];
    logic [30:0] s_next  [2];
    logic [30:0] sx_reg  [2][5];
    logic [30:0] sq_reg  [2][4];
    logic [30:0] st_reg  [2][4];
    logic [30:0] ss_reg  [2];

    always_comb
    begin
        lane_x[0] = {1'b0, f_reg};
        lane_x[1] = ONE_Q30 - {1'b0, f_reg};
        for (int l = 0; l < 2; l++)
        begin
            sq_prod[l] = 62'(lane_x[l]) * 62'(lane_x[l]);
            hp[l][0]   = 62'(SIN_COEF[0]) * 62'(sq_reg[l][0]);
            for (int k = 1; k < 4; k++)
                hp[l][k] = 62'(st_reg[l][k-1]) * 62'(sq_reg[l][k]);
            for (int k = 0; k < 4; k++)
                t_next[l][k] = SIN_COEF[k+1] - hp[l][k][60:30];
            fin[l]    = 62'(st_reg[l][3]) * 62'(sx_reg[l][4]);
            s_next[l] = (fin[l][61:30] > 32'(ONE_Q30)) ? ONE_Q30 : fin[l][60:30];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg       <= p32[29:0];
            side_reg[0] <= side_next;
            for (int i = 1; i < SINE_LAT; i++)
                side_reg[i] <= side_reg[i-1];
            for (int l = 0; l < 2; l++)
            begin
                sx_reg[l][0] <= lane_x[l];
                sq_reg[l][0] <= sq_prod[l][60:30];
                for (int k = 1; k < 5; k++)
                    sx_reg[l][k] <= sx_reg[l][k-1];
                for (int k = 1; k < 4; k++)
                    sq_reg[l][k] <= sq_reg[l][k-1];
                for (int k = 0; k < 4; k++)
                    st_reg[l][k] <= t_next[l][k];
                ss_reg[l] <= s_next[l];
            end
        end
    end

    // Map the quadrant onto cosine and sine
    sine_side_t sl;
    logic [30:0] cos_mag;
    logic [30:0] sin_mag;
    logic        cos_neg;
    logic        sin_neg;

    always_comb
    begin
        sl      = side_reg[SINE_LAT-1];
        cos_mag = sl.quad[0] ? ss_reg[0] : ss_reg[1];
        sin_mag = sl.quad[0] ? ss_reg[1] : ss_reg[0];
        cos_neg = sl.quad[0] ^ sl.quad[1];
        sin_neg = sl.quad[1];
    end

    logic signed [SAMPLE_WIDTH-1:0] px;
    logic signed [SAMPLE_WIDTH-1:0] py;

    sep_axis #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis_x (
        .clk      (clk),
        .en       (adv),
        .trig     (cos_mag),
        .trig_neg (cos_neg),
        .amp      (sl.ax),
        .n        (sl.n),
        .point    (px)
    );

    sep_axis #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis_y (
        .clk      (clk),
        .en       (adv),
        .trig     (sin_mag),
        .trig_neg (sin_neg),
        .amp      (sl.ay),
        .n        (sl.n),
        .point    (py)
    );

    // Drive the result beat; a zero exponent forces both points to zero
    assign m_tvalid = flag_reg[PIPE_LAT-1].vld;
    assign m_tuser  = flag_reg[PIPE_LAT-1].inv;
    assign m_tdata  = flag_reg[PIPE_LAT-1].inv ? '0 : OUT_W'({py, px});

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        adv && flag_reg[PIPE_LAT-2].vld |=> m_tvalid)
        else $error("beat lost at pipeline exit");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(flag_reg[0].vld) && $stable(flag_reg[PIPE_LAT/2].vld))
        else $error("pipeline moved during stall");

    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("invalid beat carries nonzero point");

endmodule
